@@ hdl/residue_class_next_value_macros.svh @@
// ----------------------------------------------------------------------------
// Residue class stepper assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef RESIDUE_CLASS_NEXT_VALUE_MACROS_SVH
`define RESIDUE_CLASS_NEXT_VALUE_MACROS_SVH

// same-cycle implication, reset disabled
`define RCNV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcnv check failed");

// next-cycle implication, reset disabled
`define RCNV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcnv check failed");

`endif

@@ hdl/rcnv_pkg.sv @@
// ----------------------------------------------------------------------------
// Residue class stepper package
// Types and constants shared by the cells, the finish stage and the top.
// ----------------------------------------------------------------------------
`default_nettype none
package rcnv_pkg;

  localparam int unsigned VW = 64;
  localparam int unsigned MW = 32;
  localparam logic [VW-1:0] NS_LIMIT = 64'd999999999;

  typedef enum logic [1:0] {
    MODE_SEQ   = 2'd0,
    MODE_VAL   = 2'd1,
    MODE_ALIGN = 2'd2,
    MODE_NSNXT = 2'd3
  } mode_t;

  typedef enum logic {
    REG_BASE    = 1'b0,
    REG_MODULUS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic          vld;
    mode_t         mode;
    logic [VW-1:0] v;
    logic [VW-1:0] d;
    logic [MW-1:0] rem;
  } cell_word_t;

endpackage
`default_nettype wire

@@ hdl/rcnv_cell.sv @@
// ----------------------------------------------------------------------------
// Residue class stepper division cell
// One restoring remainder step: take the next dividend bit, subtract modulus.
// ----------------------------------------------------------------------------
`default_nettype none
module rcnv_cell (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    adv,
  input  wire logic [rcnv_pkg::MW-1:0] modulus,
  input  wire rcnv_pkg::cell_word_t    din,
  output rcnv_pkg::cell_word_t         dout
);
  import rcnv_pkg::*;

  cell_word_t  word_r, word_nxt;
  logic [MW:0] trial, diff;

  always_comb begin
    trial    = {din.rem, din.d[VW-1]};
    diff     = trial - {1'b0, modulus};
    word_nxt = din;
    word_nxt.d   = {din.d[VW-2:0], din.d[VW-1]};
    word_nxt.rem = (trial >= {1'b0, modulus}) ? diff[MW-1:0] : trial[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.vld <= 1'b0;
    end else if (adv) begin
      word_r.vld <= word_nxt.vld;
    end
    if (adv) begin
      word_r.mode <= word_nxt.mode;
      word_r.v    <= word_nxt.v;
      word_r.d    <= word_nxt.d;
      word_r.rem  <= word_nxt.rem;
    end
  end

  assign dout = word_r;
endmodule
`default_nettype wire

@@ hdl/rcnv_fin.sv @@
// ----------------------------------------------------------------------------
// Residue class stepper finish stage
// Rebuild the class member from the remainder and apply per-mode rules.
// ----------------------------------------------------------------------------
`default_nettype none
module rcnv_fin (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    adv,
  input  wire logic                    plain,
  input  wire logic [rcnv_pkg::MW-1:0] base,
  input  wire logic [rcnv_pkg::MW-1:0] modulus,
  input  wire rcnv_pkg::cell_word_t    din,
  output logic                         out_valid,
  output logic [rcnv_pkg::VW-1:0]      out_result
);
  import rcnv_pkg::*;

  logic          vld_r;
  mode_t         mode_r;
  logic [VW-1:0] v_r, d_r, sum_r, summ_r;
  logic [VW-1:0] sum_nxt, summ_nxt;
  logic          ovld_r;
  logic [VW-1:0] res_r, res_nxt;
  logic [VW-1:0] m64, b64, floor64, lim_m;
  logic [MW-1:0] v32, s32, d32;

  assign m64     = {{(VW-MW){1'b0}}, modulus};
  assign b64     = {{(VW-MW){1'b0}}, base};
  assign floor64 = (base != '0) ? b64 : m64;
  assign lim_m   = NS_LIMIT - m64;
  assign sum_nxt  = din.d - {{(VW-MW){1'b0}}, din.rem} + b64;
  assign summ_nxt = sum_nxt - m64;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      ovld_r <= 1'b0;
    end else if (adv) begin
      vld_r  <= din.vld;
      ovld_r <= vld_r;
    end
    if (adv) begin
      mode_r <= din.mode;
      v_r    <= din.v;
      d_r    <= din.d;
      sum_r  <= sum_nxt;
      summ_r <= summ_nxt;
      res_r  <= res_nxt;
    end
  end

  always_comb begin
    v32 = v_r[MW-1:0];
    s32 = sum_r[MW-1:0];
    d32 = d_r[MW-1:0];
    res_nxt = '0;
    case (mode_r)
      MODE_SEQ: begin
        if (plain) res_nxt = v_r + 64'd1;
        else if (sum_r <= d_r) res_nxt = sum_r + m64;
        else res_nxt = sum_r;
      end
      MODE_VAL: begin
        if (plain) res_nxt = {{(VW-MW){1'b0}}, MW'(v32 + 32'd1)};
        else if (s32 <= d32) begin
          if (s32 > ~modulus) res_nxt = {{(VW-MW){1'b0}}, MW'(v32 + 32'd1)};
          else res_nxt = {{(VW-MW){1'b0}}, MW'(s32 + modulus)};
        end else res_nxt = {{(VW-MW){1'b0}}, s32};
      end
      MODE_ALIGN: begin
        if (plain) res_nxt = v_r;
        else if ($signed(sum_r) > $signed(NS_LIMIT)) begin
          res_nxt = ($signed(summ_r) < 64'sd1) ? floor64 : summ_r;
        end else begin
          res_nxt = ($signed(sum_r) < 64'sd1) ? floor64 : sum_r;
        end
      end
      MODE_NSNXT: begin
        if (plain) res_nxt = ($signed(v_r) >= $signed(NS_LIMIT)) ? 64'd1 : v_r + 64'd1;
        else if ($signed(v_r) > $signed(lim_m)) res_nxt = floor64;
        else res_nxt = v_r + m64;
      end
      default: res_nxt = '0;
    endcase
  end

  assign out_valid  = ovld_r;
  assign out_result = res_r;
endmodule
`default_nettype wire

@@ hdl/residue_class_next_value.sv @@
// Pipeline: 66 register stages (64 remainder cells, two finish stages); the result
// word passes through the cells in order, then both finish stages, to out_result.
// Throughput: one word per cycle; the whole chain holds while a result waits.
// Reset: synchronous active-low rst_n clears all valid bits; base resets to 0,
// modulus to 1.
// ----------------------------------------------------------------------------
// Residue class stepper top level
// Chain of restoring remainder cells feeding a per-mode finish stage.
// ----------------------------------------------------------------------------
`default_nettype none
module residue_class_next_value (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              in_mode,
  input  wire logic [63:0]             in_value,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [63:0]                  out_result,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic                    cfg_index,
  input  wire logic [31:0]             cfg_data
);
  import rcnv_pkg::*;

  logic [MW-1:0] base_r, mod_r, base_eff, mod_eff;
  logic          pair_ok, plain, adv;
  logic [VW-1:0] dvd;
  cell_word_t    chain [0:VW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      mod_r  <= 32'd1;
    end else if (cfg_valid) begin
      if (cfg_index == REG_BASE) base_r <= cfg_data;
      else mod_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign pair_ok   = (mod_r != '0) && (base_r < mod_r);
  assign base_eff  = pair_ok ? base_r : '0;
  assign mod_eff   = pair_ok ? mod_r : 32'd1;
  assign plain     = (mod_eff == 32'd1);
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;

  always_comb begin
    case (mode_t'(in_mode))
      MODE_VAL:   dvd = {{(VW-MW){1'b0}}, in_value[MW-1:0]};
      MODE_ALIGN: dvd = ($signed(in_value) < 0 || $signed(in_value) > $signed(NS_LIMIT))
                        ? '0 : in_value;
      default:    dvd = in_value;
    endcase
    chain[0].vld  = in_valid;
    chain[0].mode = mode_t'(in_mode);
    chain[0].v    = in_value;
    chain[0].d    = dvd;
    chain[0].rem  = '0;
  end

  for (genvar i = 0; i < VW; i++) begin : g_cell
    rcnv_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .modulus (mod_eff),
      .din     (chain[i]),
      .dout    (chain[i+1])
    );
  end

  rcnv_fin u_fin (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .plain      (plain),
    .base       (base_eff),
    .modulus    (mod_eff),
    .din        (chain[VW]),
    .out_valid  (out_valid),
    .out_result (out_result)
  );
endmodule
`default_nettype wire

@@ hdl/rcnv_chk.sv @@
// ----------------------------------------------------------------------------
// Residue class stepper port checker
// Watches handshake and flow behavior at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
`include "residue_class_next_value_macros.svh"
module rcnv_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic cfg_ready,
  input wire logic [63:0] out_result
);
  `RCNV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_result))
  `RCNV_ASSERT_NOW(a_ready_flow, clk, rst_n, 1'b1, in_ready == (!out_valid || out_ready))
  `RCNV_ASSERT_NOW(a_cfg_open, clk, rst_n, 1'b1, cfg_ready)
  `RCNV_ASSERT_NEXT(a_reset_empty, clk, 1'b1, !rst_n, !out_valid)
endmodule

bind residue_class_next_value rcnv_chk u_rcnv_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .cfg_ready  (cfg_ready),
  .out_result (out_result)
);
`default_nettype wire
